FILE: rtl/sfl_pkg.sv
// Shared types and constants of the serial flash loader command engine.
package sfl_pkg;

	localparam int PageBytesDef = 128;
	localparam int AddrBitsDef = 24;

	// Input actions
	localparam logic [1:0] ACT_BYTE  = 2'd0;
	localparam logic [1:0] ACT_TICK  = 2'd1;
	localparam logic [1:0] ACT_FLASH = 2'd2;

	// Result kinds
	localparam logic [2:0] K_SEND    = 3'd0;
	localparam logic [2:0] K_ERASE   = 3'd1;
	localparam logic [2:0] K_FILL    = 3'd2;
	localparam logic [2:0] K_WRITE   = 3'd3;
	localparam logic [2:0] K_READ    = 3'd4;
	localparam logic [2:0] K_RESTART = 3'd5;

	// Configuration register indexes
	localparam logic [1:0] REG_BOOT = 2'd0;
	localparam logic [1:0] REG_SIG  = 2'd1;
	localparam logic [1:0] REG_WIDE = 2'd2;
	localparam logic [1:0] REG_TOUT = 2'd3;

	typedef enum logic [2:0] {
		PH_IDLE, PH_MATCH, PH_DRAIN, PH_ADDR, PH_WRITE, PH_READ
	} phase_t;

	typedef enum logic [2:0] {
		CMD_INFO, CMD_HELP, CMD_EXIT, CMD_SET, CMD_GET, CMD_READ, CMD_WRITE, CMD_NONE
	} cmd_t;

	// Reply runs the back end expands
	typedef enum logic [3:0] {
		RUN_NONE, RUN_QUERY, RUN_ERROR, RUN_INFO, RUN_EXIT, RUN_ADDR,
		RUN_READ_START, RUN_ERASE, RUN_FILL, RUN_PAGE_DONE, RUN_READ_BYTE,
		RUN_READ_END
	} run_t;

	// One queued job: run code plus the values captured when it was decided
	typedef struct packed {
		run_t        run;
		logic [7:0]  data;
		logic [7:0]  sum;
		logic [23:0] addr;
		logic [15:0] word;
		logic [23:0] sig;
		logic [23:0] boot;
	} job_t;

	function automatic logic [7:0] suffix_len(input cmd_t c);
		case (c)
			CMD_SET, CMD_GET: suffix_len = 8'd5;
			CMD_WRITE:        suffix_len = 8'd4;
			CMD_NONE:         suffix_len = 8'd0;
			default:          suffix_len = 8'd3;
		endcase
	endfunction

	function automatic logic [7:0] suffix_char(input cmd_t c, input logic [2:0] p);
		logic [39:0] s;
		s = 40'd0;
		case (c)
			CMD_INFO:  s = {16'd0, "ofn"};
			CMD_HELP:  s = {16'd0, "ple"};
			CMD_EXIT:  s = {16'd0, "tix"};
			CMD_SET:   s = "rdate";
			CMD_GET:   s = "tegrd";
			CMD_READ:  s = {16'd0, "dae"};
			CMD_WRITE: s = {8'd0, "etir"};
			default:   s = 40'd0;
		endcase
		case (p)
			3'd0:    suffix_char = s[7:0];
			3'd1:    suffix_char = s[15:8];
			3'd2:    suffix_char = s[23:16];
			3'd3:    suffix_char = s[31:24];
			3'd4:    suffix_char = s[39:32];
			default: suffix_char = 8'd0;
		endcase
	endfunction

endpackage

FILE: rtl/sfl_front.sv
// Front end: accepts words, runs the command decoder and queues reply jobs.
module sfl_front #(
	parameter int PAGE_BYTES = sfl_pkg::PageBytesDef,
	parameter int ADDRESS_BITS = sfl_pkg::AddrBitsDef
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [1:0]          action,
	input  logic [7:0]          value,
	input  logic [23:0]         boot_start,
	input  logic [23:0]         device_signature,
	input  logic                wide_address,
	input  logic [7:0]          reply_timeout,
	output logic                job_valid,
	input  logic                job_ready,
	output sfl_pkg::job_t       job
);
	import sfl_pkg::*;

	localparam int CntW = 9;
	localparam logic [23:0] AMask = 24'((25'd1 << ADDRESS_BITS) - 25'd1);
	localparam logic [23:0] PMask = ~24'(PAGE_BYTES - 1) | ~24'hff_ffff;
	localparam logic [CntW-1:0] WrEnd = CntW'(PAGE_BYTES & ~1);
	localparam logic [CntW-1:0] RdEnd = CntW'(PAGE_BYTES);

	phase_t         phase_q, phase_d;
	cmd_t           cmd_q, cmd_d;
	logic [2:0]     pos_q, pos_d;
	logic [7:0]     tick_q, tick_d;
	logic [23:0]    page_q, page_d, work_q, work_d;
	logic [CntW-1:0] cnt_q, cnt_d;
	logic [7:0]     sum_q, sum_d, low_q, low_d;
	logic [7:0]     ticks_next;
	logic [23:0]    a_full;
	job_t           job_d;
	logic           accept;

	// Each item produces at most one job, so ready only waits on the job slot
	assign in_ready = !job_valid || job_ready;
	assign accept = in_valid && in_ready;
	assign ticks_next = tick_q + 8'd1;
	assign a_full = ({(wide_address ? value : 8'd0), work_q[15:0]} & AMask) & PMask;

	always_comb begin
		phase_d = phase_q; cmd_d = cmd_q; pos_d = pos_q; tick_d = tick_q;
		page_d = page_q; work_d = work_q; cnt_d = cnt_q; sum_d = sum_q; low_d = low_q;
		job_d = '0;
		job_d.run = RUN_NONE;
		job_d.sig = device_signature;
		job_d.boot = boot_start;
		job_d.data = wide_address ? 8'd1 : 8'd0;
		if (action == ACT_BYTE) begin
			case (phase_q)
				PH_MATCH: begin
					if ({5'd0, pos_q} < suffix_len(cmd_q) && value != suffix_char(cmd_q, pos_q)) begin
						job_d.run = RUN_ERROR; phase_d = PH_DRAIN; tick_d = '0;
					end else begin
						pos_d = pos_q + 3'd1;
						tick_d = '0;
						if ({5'd0, pos_q} + 8'd1 >= suffix_len(cmd_q)) begin
							phase_d = PH_IDLE;
							case (cmd_q)
								CMD_INFO: job_d.run = RUN_INFO;
								CMD_EXIT: job_d.run = RUN_EXIT;
								CMD_SET: begin
									phase_d = PH_ADDR; cnt_d = '0; work_d = '0;
								end
								CMD_GET: begin
									job_d.run = RUN_ADDR; job_d.addr = page_q;
								end
								CMD_READ: begin
									job_d.run = RUN_READ_START; job_d.addr = page_q & AMask;
									work_d = page_q & AMask; cnt_d = '0; sum_d = '0;
									phase_d = PH_READ;
								end
								CMD_WRITE: begin
									job_d.run = RUN_ERASE; job_d.addr = page_q & AMask;
									work_d = page_q & AMask; cnt_d = '0; sum_d = '0;
									phase_d = PH_WRITE;
								end
								default: ;
							endcase
						end
					end
				end
				PH_DRAIN: tick_d = '0;
				PH_ADDR: begin
					tick_d = '0;
					if (cnt_q == '0) begin
						work_d = {16'd0, value}; cnt_d = CntW'(1);
					end else if (cnt_q == CntW'(1)) begin
						work_d = work_q | {8'd0, value, 8'd0}; cnt_d = CntW'(2);
					end else begin
						work_d = a_full; cnt_d = '0;
						if (a_full >= boot_start) begin
							job_d.run = RUN_ERROR; phase_d = PH_DRAIN;
						end else begin
							page_d = a_full; phase_d = PH_IDLE;
							job_d.run = RUN_ADDR; job_d.addr = a_full;
						end
					end
				end
				PH_WRITE: begin
					tick_d = '0;
					sum_d = sum_q + value;
					if (!cnt_q[0]) begin
						low_d = value;
					end else begin
						job_d.run = RUN_FILL; job_d.addr = work_q;
						job_d.word = {value, low_q};
						work_d = (work_q + 24'd2) & AMask;
					end
					cnt_d = cnt_q + CntW'(1);
					if (cnt_q + CntW'(1) >= WrEnd) begin
						// Fill (if any) and page completion travel as one job
						job_d.run = (cnt_q[0]) ? RUN_PAGE_DONE : RUN_PAGE_DONE;
						job_d.data = cnt_q[0] ? 8'd1 : 8'd0;
						job_d.sum = sum_q + value;
						job_d.boot = page_q & AMask;
						cnt_d = '0; phase_d = PH_IDLE;
					end
				end
				PH_READ: ;
				default: begin
					phase_d = PH_IDLE;
					case (value)
						"?": job_d.run = RUN_QUERY;
						"i": cmd_d = CMD_INFO;
						"h": cmd_d = CMD_HELP;
						"e": cmd_d = CMD_EXIT;
						"s": cmd_d = CMD_SET;
						"a": cmd_d = CMD_GET;
						"r": cmd_d = CMD_READ;
						"w": cmd_d = CMD_WRITE;
						default: begin
							job_d.run = RUN_ERROR; phase_d = PH_DRAIN; tick_d = '0;
						end
					endcase
					if (value != "?" && job_d.run != RUN_ERROR) begin
						pos_d = '0; tick_d = '0; phase_d = PH_MATCH;
					end
				end
			endcase
		end else if (action == ACT_TICK) begin
			if (phase_q == PH_MATCH || phase_q == PH_ADDR || phase_q == PH_WRITE) begin
				tick_d = ticks_next;
				if (ticks_next == reply_timeout) begin
					job_d.run = RUN_ERROR; phase_d = PH_DRAIN; tick_d = '0;
				end
			end else if (phase_q == PH_DRAIN) begin
				tick_d = ticks_next;
				if (ticks_next == reply_timeout) begin
					phase_d = PH_IDLE; tick_d = '0;
				end
			end
		end else if (action == ACT_FLASH && phase_q == PH_READ) begin
			sum_d = sum_q + value;
			cnt_d = cnt_q + CntW'(1);
			work_d = (work_q + 24'd1) & AMask;
			job_d.data = value;
			if (cnt_q + CntW'(1) >= RdEnd) begin
				job_d.run = RUN_READ_END; job_d.sum = sum_q + value;
				cnt_d = '0; phase_d = PH_IDLE; tick_d = '0;
			end else begin
				job_d.run = RUN_READ_BYTE; job_d.addr = (work_q + 24'd1) & AMask;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE; cmd_q <= CMD_INFO; pos_q <= '0; tick_q <= '0;
			page_q <= '0; work_q <= '0; cnt_q <= '0; sum_q <= '0; low_q <= '0;
			job_valid <= 1'b0;
		end else begin
			if (job_valid && job_ready) job_valid <= 1'b0;
			if (accept) begin
				phase_q <= phase_d; cmd_q <= cmd_d; pos_q <= pos_d; tick_q <= tick_d;
				page_q <= page_d; work_q <= work_d; cnt_q <= cnt_d; sum_q <= sum_d;
				low_q <= low_d;
				if (job_d.run != RUN_NONE) job_valid <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) job <= job_d;
	end

endmodule

FILE: rtl/sfl_back.sv
// Back end: expands one queued job into its run of result words.
module sfl_back #(
	parameter int PAGE_BYTES = sfl_pkg::PageBytesDef
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          job_valid,
	output logic          job_ready,
	input  sfl_pkg::job_t job,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [2:0]    kind,
	output logic [7:0]    tx_byte,
	output logic [23:0]   flash_address,
	output logic [15:0]   flash_word,
	output logic          last
);
	import sfl_pkg::*;

	localparam logic [15:0] PB = 16'(PAGE_BYTES);

	job_t       cur_q;
	logic       busy_q;
	logic [3:0] idx_q;
	logic [3:0] len;
	logic [2:0] k;
	logic [7:0] b;
	logic [23:0] fa;
	logic [15:0] fw;
	logic        wide;

	assign wide = cur_q.data[0];

	// Select the word at position idx_q of the current run
	always_comb begin
		k = K_SEND; b = 8'd0; fa = 24'd0; fw = 16'd0; len = 4'd1;
		case (cur_q.run)
			RUN_QUERY: begin
				len = 4'd3;
				case (idx_q)
					4'd0: b = "F";
					4'd1: b = "4";
					default: b = 8'd13;
				endcase
			end
			RUN_ERROR: begin
				len = 4'd6;
				case (idx_q)
					4'd0: b = "e";
					4'd1, 4'd2, 4'd4: b = "r";
					4'd3: b = "o";
					default: b = 8'd13;
				endcase
			end
			RUN_INFO: begin
				len = 4'd10;
				case (idx_q)
					4'd0: b = "I";
					4'd1: b = cur_q.sig[7:0];
					4'd2: b = cur_q.sig[15:8];
					4'd3: b = cur_q.sig[23:16];
					4'd4: b = PB[7:0];
					4'd5: b = PB[15:8];
					4'd6: b = cur_q.boot[7:0];
					4'd7: b = cur_q.boot[15:8];
					4'd8: b = cur_q.boot[23:16];
					default: b = 8'd13;
				endcase
			end
			RUN_EXIT: begin
				len = 4'd2;
				if (idx_q == 4'd0) b = "@";
				else k = K_RESTART;
			end
			RUN_ADDR: begin
				len = 4'd5;
				case (idx_q)
					4'd0: b = "A";
					4'd1: b = cur_q.addr[7:0];
					4'd2: b = cur_q.addr[15:8];
					4'd3: b = wide ? cur_q.addr[23:16] : 8'd0;
					default: b = 8'd13;
				endcase
			end
			RUN_READ_START: begin
				len = 4'd2;
				if (idx_q == 4'd0) b = "R";
				else begin k = K_READ; fa = cur_q.addr; end
			end
			RUN_ERASE: begin k = K_ERASE; fa = cur_q.addr; end
			RUN_FILL: begin k = K_FILL; fa = cur_q.addr; fw = cur_q.word; end
			RUN_PAGE_DONE: begin
				// data[0] set: a fill word leads the run
				len = wide ? 4'd5 : 4'd4;
				case (wide ? idx_q : idx_q + 4'd1)
					4'd0: begin k = K_FILL; fa = cur_q.addr; fw = cur_q.word; end
					4'd1: begin k = K_WRITE; fa = cur_q.boot; end
					4'd2: b = "W";
					4'd3: b = cur_q.sum;
					default: b = 8'd13;
				endcase
			end
			RUN_READ_BYTE: begin
				len = 4'd2;
				if (idx_q == 4'd0) b = cur_q.data;
				else begin k = K_READ; fa = cur_q.addr; end
			end
			RUN_READ_END: begin
				len = 4'd3;
				case (idx_q)
					4'd0: b = cur_q.data;
					4'd1: b = cur_q.sum;
					default: b = 8'd13;
				endcase
			end
			default: ;
		endcase
	end

	logic fire, done;
	assign fire = out_valid && out_ready;
	assign done = fire && (idx_q + 4'd1 == len);
	assign job_ready = !busy_q || done;
	assign out_valid = busy_q;
	assign kind = k;
	assign tx_byte = b;
	assign flash_address = fa;
	assign flash_word = fw;
	assign last = (idx_q + 4'd1 == len);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0; idx_q <= '0;
		end else if (job_valid && job_ready) begin
			busy_q <= 1'b1; idx_q <= '0;
		end else if (done) begin
			busy_q <= 1'b0; idx_q <= '0;
		end else if (fire) begin
			idx_q <= idx_q + 4'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (job_valid && job_ready) cur_q <= job;
	end

endmodule

FILE: rtl/serial_flash_loader_command_engine_core.sv
// Top level of the serial flash loader command engine.
//   channel | direction | handshake            | payload
//   in      | input     | in_valid / in_ready  | action, value
//   out     | output    | out_valid / out_ready| kind, tx_byte, flash_address, flash_word, last
//   cfg     | input     | cfg_we               | cfg_index, cfg_data
// An input word is decoded in the cycle it is accepted and leaves at most one job; the
// back end takes it from the job slot once idle or finishing, and sends its run (1 to 10
// words) one word a cycle while the output is not stalled.
// The front takes the next word once the job slot is empty or being emptied; a stalled
// output holds the run and, once the slot is full, the input.
// Reset clears all control state and loads the register defaults.
module serial_flash_loader_command_engine_core #(
	parameter int PAGE_BYTES = sfl_pkg::PageBytesDef,
	parameter int ADDRESS_BITS = sfl_pkg::AddrBitsDef
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  action,
	input  logic [7:0]  value,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  kind,
	output logic [7:0]  tx_byte,
	output logic [23:0] flash_address,
	output logic [15:0] flash_word,
	output logic        last,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [23:0] cfg_data
);
	import sfl_pkg::*;

	logic [23:0] boot_q, sig_q;
	logic        wide_q;
	logic [7:0]  tout_q;
	logic        job_valid, job_ready;
	job_t        job;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			boot_q <= 24'd28672; sig_q <= 24'd2003970; wide_q <= 1'b0; tout_q <= 8'd100;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_BOOT: boot_q <= cfg_data;
				REG_SIG:  sig_q <= cfg_data;
				REG_WIDE: wide_q <= cfg_data[0];
				REG_TOUT: tout_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	sfl_front #(.PAGE_BYTES(PAGE_BYTES), .ADDRESS_BITS(ADDRESS_BITS)) u_front (
		.clk, .arst_n, .in_valid, .in_ready, .action, .value,
		.boot_start(boot_q), .device_signature(sig_q), .wide_address(wide_q),
		.reply_timeout(tout_q), .job_valid, .job_ready, .job
	);

	sfl_back #(.PAGE_BYTES(PAGE_BYTES)) u_back (
		.clk, .arst_n, .job_valid, .job_ready, .job, .out_valid, .out_ready,
		.kind, .tx_byte, .flash_address, .flash_word, .last
	);

endmodule

FILE: rtl/sfl_checker.sv
// Port-level checks of the command engine, bound to the top level.
module sfl_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [2:0]  kind,
	input logic [7:0]  tx_byte,
	input logic [23:0] flash_address,
	input logic        last
);
	import sfl_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(tx_byte))
		else $error("result word changed while stalled");

	a_kind_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> kind <= K_RESTART)
		else $error("result kind out of range");

	a_send_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == K_SEND |-> flash_address == 24'd0)
		else $error("send word carries an address");

	a_restart_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == K_RESTART |-> last)
		else $error("restart is not the final word");

	// an idle back end always leaves room for the next word
	a_in_open: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input blocked with nothing in flight");

endmodule

bind serial_flash_loader_command_engine_core sfl_checker u_chk (
	.clk, .arst_n, .in_ready, .out_valid, .out_ready,
	.kind, .tx_byte, .flash_address, .last
);
